[rtl/buddy_block_allocator_assert.svh]
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bba_pkg.sv]
// Package: item types, codes, controller states and control structs.
package bba_pkg;

  localparam int OW    = 5;
  localparam int CFG_W = 4;

  localparam int BLK_SHIFT      = 5;
  localparam int MAX_POOL_ORDER = 10;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] req_size;
    logic [14:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] alloc_offset;
    logic [3:0]  block_order;
  } rsp_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE,
    S_A_SEARCH, S_A_SPLIT, S_A_POPWT, S_A_PUSHB, S_A_PUSHL, S_A_FINWT,
    S_F_CHECK, S_F_SCANRD, S_F_SCANWT, S_F_MOVRD, S_F_MOVWT, S_F_PUSH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic init_wr;
    logic e_inc;
    logic e_dec;
    logic pop;
    logic take_blk;
    logic push_buddy;
    logic push_blk;
    logic scan_init;
    logic scan_rd;
    logic mov_rd;
    logic mov_wr;
    logic take_done;
    logic res_err1;
    logic res_err2;
    logic res_alloc;
    logic res_free;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic ord_gt_pool;
    logic e_gt_pool;
    logic e_gt_ord;
    logic e_lt_pool;
    logic cnt_zero;
    logic i_zero;
    logic match;
    logic j_last;
  } dp_stat_t;

endpackage

[rtl/bba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/bba_ctrl.sv]
// Controller: sequences search, split, scan, compaction and merge steps.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_acc,
  input  logic     in_valid,
  input  logic     out_ready,
  input  dp_stat_t st,
  output logic     in_ready,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else if (cfg_acc) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT:     state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (st.ord_gt_pool) state_next = S_OUT;
        else if (st.is_free) state_next = S_F_CHECK;
        else state_next = S_A_SEARCH;
      end
      S_A_SEARCH: begin
        if (st.e_gt_pool) state_next = S_OUT;
        else if (!st.cnt_zero) state_next = S_A_SPLIT;
      end
      S_A_SPLIT:  state_next = st.e_gt_ord ? S_A_POPWT : S_A_FINWT;
      S_A_POPWT:  state_next = S_A_PUSHB;
      S_A_PUSHB:  state_next = S_A_PUSHL;
      S_A_PUSHL:  state_next = S_A_SPLIT;
      S_A_FINWT:  state_next = S_OUT;
      S_F_CHECK:  state_next = st.e_lt_pool ? S_F_SCANRD : S_F_PUSH;
      S_F_SCANRD: state_next = st.i_zero ? S_F_PUSH : S_F_SCANWT;
      S_F_SCANWT: state_next = st.match ? S_F_MOVRD : S_F_SCANRD;
      S_F_MOVRD:  state_next = st.j_last ? S_F_CHECK : S_F_MOVWT;
      S_F_MOVWT:  state_next = S_F_MOVRD;
      S_F_PUSH:   state_next = S_OUT;
      S_OUT:      if (out_ready) state_next = S_IDLE;
      default:    state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_INIT:     cmd.init_wr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.res_err1 = st.ord_gt_pool && !st.is_free;
        cmd.res_err2 = st.ord_gt_pool && st.is_free;
      end
      S_A_SEARCH: begin
        cmd.res_err1 = st.e_gt_pool;
        cmd.e_inc    = !st.e_gt_pool && st.cnt_zero;
      end
      S_A_SPLIT:  cmd.pop = 1'b1;
      S_A_POPWT: begin
        cmd.take_blk = 1'b1;
        cmd.e_dec    = 1'b1;
      end
      S_A_PUSHB:  cmd.push_buddy = 1'b1;
      S_A_PUSHL:  cmd.push_blk = 1'b1;
      S_A_FINWT:  cmd.res_alloc = 1'b1;
      S_F_CHECK:  cmd.scan_init = st.e_lt_pool;
      S_F_SCANRD: cmd.scan_rd = !st.i_zero;
      S_F_MOVRD: begin
        cmd.mov_rd    = !st.j_last;
        cmd.take_done = st.j_last;
      end
      S_F_MOVWT:  cmd.mov_wr = 1'b1;
      S_F_PUSH: begin
        cmd.push_blk = 1'b1;
        cmd.res_free = 1'b1;
      end
      S_OUT:      out_valid = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

[rtl/bba_dp.sv]
// Datapath: list counts, free-list store, request and result registers.
module bba_dp import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_acc,
  input  logic [CFG_W-1:0] cfg_data,
  input  req_t             req,
  input  dp_cmd_t          cmd,
  output dp_stat_t         st,
  output rsp_t             rsp
);

  localparam int AW  = MAX_POOL_ORDER + 1;
  localparam int DW  = MAX_POOL_ORDER;
  localparam int CW  = MAX_POOL_ORDER + 1;
  localparam int NO  = MAX_POOL_ORDER + 1;
  localparam int CIW = $clog2(NO);

  function automatic logic [AW-1:0] base_of(logic [OW-1:0] k);
    logic [AW:0] full;
    full = (AW+1)'(1) << AW;
    return AW'(full - (full >> k));
  endfunction

  function automatic logic [CW-1:0] cap_of(logic [OW-1:0] k);
    logic [AW:0] full;
    full = (AW+1)'(1) << AW;
    return CW'((full >> 1) >> k);
  endfunction

  function automatic logic [OW-1:0] order_of(logic [15:0] size);
    logic [16:0] needed;
    logic [16:0] nm1;
    logic [OW-1:0] o;
    needed = ({1'b0, size} + 17'((32'(1) << BLK_SHIFT) - 32'(1))) >> BLK_SHIFT;
    nm1    = (needed > 17'd1) ? needed - 17'd1 : 17'd0;
    o      = '0;
    for (int b = 0; b < 17; b++) begin
      if (nm1[b]) o = OW'(b + 1);
    end
    return o;
  endfunction

  logic [OW-1:0] pool, pool_next;
  logic [CW-1:0] count [NO];
  logic          is_free;
  logic [OW-1:0] ord;
  logic [OW-1:0] e;
  logic [DW-1:0] blk;
  logic [CW-1:0] i;

  logic [CW-1:0] cnt_cur;
  logic [AW-1:0] base_cur;
  logic [DW-1:0] buddy;
  logic          room;
  logic [DW-1:0] rd_data;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data;

  assign pool_next = ({1'b0, cfg_data} > OW'(MAX_POOL_ORDER)) ? OW'(MAX_POOL_ORDER)
                                                              : OW'(cfg_data);
  assign cnt_cur  = (e <= OW'(MAX_POOL_ORDER)) ? count[e[CIW-1:0]] : '0;
  assign base_cur = base_of(e);
  assign buddy    = blk ^ DW'(32'(1) << e);
  assign room     = cnt_cur < cap_of(e);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = base_cur + cnt_cur;
    wr_data = blk;
    rd_en   = cmd.pop | cmd.scan_rd | cmd.mov_rd;
    rd_addr = base_cur + cnt_cur - AW'(1);
    if (cmd.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = base_of(pool);
      wr_data = '0;
    end else if (cmd.push_buddy) begin
      wr_en   = room;
      wr_data = buddy;
    end else if (cmd.push_blk) begin
      wr_en   = room;
    end else if (cmd.mov_wr) begin
      wr_en   = 1'b1;
      wr_addr = base_cur + i;
      wr_data = rd_data;
    end
    if (cmd.scan_rd) begin
      rd_addr = base_cur + i - AW'(1);
    end else if (cmd.mov_rd) begin
      rd_addr = base_cur + i + AW'(1);
    end
  end

  bba_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= OW'(MAX_POOL_ORDER);
      for (int k = 0; k < NO; k++) begin
        count[k] <= (k == MAX_POOL_ORDER) ? CW'(1) : '0;
      end
    end else if (cfg_acc) begin
      pool <= pool_next;
      for (int k = 0; k < NO; k++) begin
        count[k] <= (OW'(k) == pool_next) ? CW'(1) : '0;
      end
    end else begin
      if (cmd.pop || cmd.take_done) begin
        count[e[CIW-1:0]] <= cnt_cur - CW'(1);
      end else if ((cmd.push_buddy || cmd.push_blk) && room) begin
        count[e[CIW-1:0]] <= cnt_cur + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_free <= req.req_type;
      ord     <= order_of(req.req_size);
      e       <= order_of(req.req_size);
      blk     <= DW'((32'(req.free_offset) >> BLK_SHIFT)
                     & ((32'(1) << pool) - 32'(1)));
    end
    if (cmd.e_inc) e <= e + OW'(1);
    if (cmd.e_dec) e <= e - OW'(1);
    if (cmd.take_blk) blk <= rd_data;
    if (cmd.scan_init) i <= cnt_cur;
    if (cmd.scan_rd) i <= i - CW'(1);
    if (cmd.mov_wr) i <= i + CW'(1);
    if (cmd.take_done) begin
      if (buddy < blk) blk <= buddy;
      e <= e + OW'(1);
    end
    if (cmd.res_err1) rsp <= '{status: ST_NOSPACE, alloc_offset: '0, block_order: '0};
    if (cmd.res_err2) rsp <= '{status: ST_BADFREE, alloc_offset: '0, block_order: '0};
    if (cmd.res_alloc) begin
      rsp <= '{status: ST_OK, alloc_offset: 15'(32'(rd_data) << BLK_SHIFT),
               block_order: ord[3:0]};
    end
    if (cmd.res_free) rsp <= '{status: ST_OK, alloc_offset: '0, block_order: e[3:0]};
  end

  assign st.is_free     = (is_free == REQ_FREE);
  assign st.ord_gt_pool = ord > pool;
  assign st.e_gt_pool   = e > pool;
  assign st.e_gt_ord    = e > ord;
  assign st.e_lt_pool   = e < pool;
  assign st.cnt_zero    = cnt_cur == '0;
  assign st.i_zero      = i == '0;
  assign st.match       = rd_data == buddy;
  assign st.j_last      = ({1'b0, i} + (CW+1)'(1)) >= {1'b0, cnt_cur};

endmodule

[rtl/buddy_block_allocator.sv]
// Buddy block allocator: top level joining controller and datapath.
// Channels: in (valid/ready, req_t) carries allocate or free requests;
//   out (valid/ready, rsp_t) returns status, offset and block order;
//   cfg (valid/ready, 4-bit pool order) resets the free lists.
// One item is in flight at a time: in_ready is high only when idle, and the
// next item can be taken in the cycle after the result is delivered.
// Steps per item, from acceptance to out_valid: a size error goes straight
//   to the result; an allocate searches up the levels for a free block (no
//   space ends the search) and then splits it down level by level; a free
//   scans its level's list for the buddy, moves the entries above it down to
//   close the gap and merges one level up, until no buddy is found or the
//   pool order is reached. Each free-list RAM read is registered, so pops,
//   scan reads and moves each have a wait state.
// Reset: pool order 10, top list holds block 0; an init state writes that
// entry, during which in_ready is low. A config write does the same.
// A stalled receiver holds the result in out_data; no new item is taken
// until it is delivered.
module buddy_block_allocator import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data
);

  `include "buddy_block_allocator_assert.svh"

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     cfg_acc;
  logic     rsp_err;
  logic     rsp_clean;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_acc   (cfg_acc),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .st        (st),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_acc  (cfg_acc),
    .cfg_data (cfg_data),
    .req      (in_data),
    .cmd      (cmd),
    .st       (st),
    .rsp      (out_data)
  );

  assign rsp_err   = out_data.status != ST_OK;
  assign rsp_clean = (out_data.alloc_offset == '0) && (out_data.block_order == '0);

  `BBA_ASSERT_NOW(a_one_in_flight, in_valid && in_ready, !out_valid, "item taken while busy")
  `BBA_ASSERT_NOW(a_err_zero, out_valid && rsp_err, rsp_clean, "error item not cleared")
  `BBA_ASSERT_NEXT(a_cfg_init, cfg_acc, !in_ready, "no init cycle after config")

endmodule

[tb/tb_top.sv]
// Testbench for the buddy block allocator: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
  import bba_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  req_t             in_data;
  logic             out_valid;
  logic             out_ready;
  rsp_t             out_data;

  buddy_block_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  localparam int MAX_ORD  = 10;
  localparam int MIN_ORD  = 5;
  localparam int DEPTH    = 2048;
  localparam int CHK      = 0;   // copy tracking accepted items
  localparam int PLAN     = 1;   // copy used to plan stimulus

  // two copies of the allocator state
  int unsigned free_store [2][DEPTH];
  int unsigned free_cnt   [2][MAX_ORD+1];
  int unsigned pool_ord   [2];

  req_t        pending_reqs [$];
  rsp_t        expected_rsps[$];
  int unsigned live_off [$];
  int unsigned live_ord [$];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches;
  int          rsp_seen;
  int          hold_left;
  bit          hold_done;

  function automatic int unsigned region_start(int unsigned k);
    return DEPTH - (1 << (MAX_ORD + 1 - k));
  endfunction

  function automatic void lists_reset(int c);
    for (int k = 0; k <= MAX_ORD; k++) free_cnt[c][k] = 0;
    free_store[c][region_start(pool_ord[c])] = 0;
    free_cnt[c][pool_ord[c]] = 1;
  endfunction

  function automatic void set_pool(int c, int unsigned v);
    pool_ord[c] = (v > MAX_ORD) ? MAX_ORD : v;
    lists_reset(c);
  endfunction

  function automatic void push_blk(int c, int unsigned k, int unsigned b);
    if (free_cnt[c][k] < (1 << (MAX_ORD - k))) begin
      free_store[c][region_start(k) + free_cnt[c][k]] = b;
      free_cnt[c][k]++;
    end
  endfunction

  function automatic int unsigned pop_blk(int c, int unsigned k);
    free_cnt[c][k]--;
    return free_store[c][region_start(k) + free_cnt[c][k]];
  endfunction

  function automatic bit remove_blk(int c, int unsigned k, int unsigned b);
    int unsigned n;
    int unsigned s;
    n = free_cnt[c][k];
    s = region_start(k);
    for (int i = int'(n) - 1; i >= 0; i--) begin
      if (free_store[c][s + i] == b) begin
        for (int j = i; j < int'(n) - 1; j++) free_store[c][s + j] = free_store[c][s + j + 1];
        free_cnt[c][k] = n - 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t serve_request(int c, req_t r);
    rsp_t        o;
    int unsigned need;
    int unsigned ord;
    int unsigned e;
    int unsigned b;
    int unsigned bud;
    o = '0;
    need = (int'(r.req_size) + 31) >> MIN_ORD;
    ord = 0;
    while ((1 << ord) < need) ord++;
    if (r.req_type == REQ_ALLOC) begin
      e = ord;
      while (e <= pool_ord[c] && free_cnt[c][e] == 0) e++;
      if (ord > pool_ord[c] || e > pool_ord[c]) begin
        o.status = ST_NOSPACE;
      end else begin
        while (e > ord) begin
          b = pop_blk(c, e);
          push_blk(c, e - 1, b ^ (1 << (e - 1)));
          push_blk(c, e - 1, b);
          e--;
        end
        b = pop_blk(c, ord);
        o.alloc_offset = 15'(b << MIN_ORD);
        o.block_order = 4'(ord);
      end
    end else if (ord > pool_ord[c]) begin
      o.status = ST_BADFREE;
    end else begin
      b = (int'(r.free_offset) >> MIN_ORD) & ((1 << pool_ord[c]) - 1);
      while (ord < pool_ord[c]) begin
        bud = b ^ (1 << ord);
        if (!remove_blk(c, ord, bud)) break;
        if (bud < b) b = bud;
        ord++;
      end
      push_blk(c, ord, b);
      o.block_order = 4'(ord);
    end
    return o;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) expected_rsps.push_back(serve_request(CHK, in_data));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rsp_seen <= rsp_seen + 1;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data.status !== want.status || out_data.alloc_offset !== want.alloc_offset
              || out_data.block_order !== want.block_order) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
      if (!hold_done && rsp_seen == 700) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_req(bit t, int unsigned sz, int unsigned off);
    req_t r;
    rsp_t o;
    r.req_type    = t;
    r.req_size    = 16'(sz);
    r.free_offset = 15'(off);
    pending_reqs.push_back(r);
    o = serve_request(PLAN, r);
    if (t == REQ_ALLOC && o.status == ST_OK) begin
      live_off.push_back(o.alloc_offset);
      live_ord.push_back(o.block_order);
    end
  endtask

  function automatic int unsigned size_of_order(int unsigned o);
    return (o == 0) ? $urandom_range(0, 32) : $urandom_range((16 << o) + 1, 32 << o);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool(int unsigned v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_pool(CHK, v);
    set_pool(PLAN, v);
    live_off.delete();
    live_ord.delete();
  endtask

  task automatic random_phase(int n);
    int unsigned p;
    int unsigned o;
    int          i;
    int          roll;
    p = pool_ord[PLAN];
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        queue_req($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 32767));
      end else if (live_off.size() > 0 && roll < 50) begin
        i = $urandom_range(0, live_off.size() - 1);
        queue_req(REQ_FREE, size_of_order(live_ord[i]),
                  live_off[i] | ($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : 0));
        live_off.delete(i);
        live_ord.delete(i);
      end else begin
        o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, p) : $urandom_range(0, p < 2 ? p : 2);
        queue_req(REQ_ALLOC, size_of_order(o), $urandom_range(0, 32767));
      end
    end
  endtask

  initial begin
    int unsigned pools[9];
    pools         = '{4, 0, 10, 15, 7, 2, 10, 9, 5};
    mismatches    = 0;
    rsp_seen      = 0;
    send_idle_pct = 15;
    recv_idle_pct = 71;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    set_pool(CHK, MAX_ORD);
    set_pool(PLAN, MAX_ORD);
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, pool at reset size
    queue_req(REQ_ALLOC, 0, 0);
    queue_req(REQ_ALLOC, 1, 32767);
    queue_req(REQ_ALLOC, 32, 0);
    queue_req(REQ_ALLOC, 33, 0);
    queue_req(REQ_ALLOC, 65535, 0);
    queue_req(REQ_FREE, 65535, 0);
    queue_req(REQ_ALLOC, 32768, 0);
    queue_req(REQ_FREE, 0, 32 | 31);
    queue_req(REQ_FREE, 32, 0);
    queue_req(REQ_FREE, 32, 0);
    queue_req(REQ_FREE, 64, 64);
    queue_req(REQ_FREE, 16, 96);
    queue_req(REQ_FREE, 0, 32);
    queue_req(REQ_ALLOC, 32768, 0);
    queue_req(REQ_FREE, 32768, 0);
    queue_req(REQ_FREE, 32768, 0);
    queue_req(REQ_ALLOC, 16384, 0);
    queue_req(REQ_FREE, 16384, 16384);
    queue_req(REQ_FREE, 32, 32736);
    queue_req(REQ_ALLOC, 1024, 0);
    live_off.delete();
    live_ord.delete();

    for (int ph = 0; ph < 9; ph++) begin
      write_pool(pools[ph]);
      if (ph == 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 15;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(215);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(12.0 * 4000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
